FILE: hw/rtl/tvfp_pkg.sv
// shared types, constants and helper functions of the tag=value field parser
package tvfp_pkg;

  // tag arithmetic width and output tag width
  localparam int unsigned TagBits  = 32;
  localparam int unsigned TagOutW  = 32;
  localparam int unsigned TagExtW  = (TagBits > TagOutW) ? TagBits : TagOutW;
  localparam int unsigned TagWideW = TagBits + 4;
  localparam logic [TagBits-1:0] TagHalf = TagBits'(1) << (TagBits - 1);

  // byte codes
  localparam logic [7:0] SepSoh  = 8'h01;
  localparam logic [7:0] SepPipe = 8'h7C;
  localparam logic [7:0] EqChar  = 8'h3D;
  localparam logic [7:0] PlusCh  = 8'h2B;
  localparam logic [7:0] MinusCh = 8'h2D;

  // output queue geometry
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned MaxRecs    = 3;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_SIGN   = 6'b000010,
    PH_DIGITS = 6'b000100,
    PH_AFTER  = 6'b001000,
    PH_REJECT = 6'b010000,
    PH_VALUE  = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_END   = 2'd2
  } record_kind_e;

  typedef struct packed {
    record_kind_e        kind;
    logic [TagOutW-1:0]  tag;
    logic [7:0]          vbyte;
    logic                last;
  } rec_t;

  // records produced by one byte, slot 0 first
  typedef struct packed {
    logic [1:0]            count;
    rec_t [MaxRecs-1:0]    recs;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // two's complement tag, low bits only
  function automatic logic [TagOutW-1:0] tag_to_out(input logic neg,
                                                    input logic [TagBits-1:0] mag);
    logic [TagExtW-1:0] ext;
    logic [TagExtW-1:0] v;
    ext = TagExtW'(mag);
    v   = neg ? (TagExtW'(0) - ext) : ext;
    return v[TagOutW-1:0];
  endfunction

endpackage

FILE: hw/rtl/tvfp_in_reg.sv
// input register stage for message bytes
module tvfp_in_reg import tvfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_eom_i,
  input  logic       consume_i,
  output logic       hold_valid_o,
  output logic [7:0] hold_byte_o,
  output logic       hold_eom_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       eom_q;

  // free when empty or when the held byte leaves this cycle
  assign in_ready_o = !valid_q || consume_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      eom_q  <= in_eom_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_byte_o  = byte_q;
  assign hold_eom_o   = eom_q;

endmodule

FILE: hw/rtl/tvfp_parser.sv
// field scanner: tag parse, value byte hold-back and record generation
module tvfp_parser import tvfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       consume_i,
  input  logic [7:0] byte_i,
  input  logic       eom_i,
  output push_t      push_o
);

  logic               soh_q;
  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [TagBits-1:0] mag_q, mag_d;
  logic               inval_q, inval_d;
  logic [7:0]         pb_q, pb_d;
  logic               pv_q, pv_d;

  logic [7:0]          sep;
  logic [1:0]          n;
  rec_t [MaxRecs-1:0]  recs;
  logic [TagWideW-1:0] wide;
  logic [TagBits-1:0]  lim;
  logic [TagOutW-1:0]  tagv;

  // separator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soh_q <= 1'b1;
    end else if (cfg_we_i) begin
      soh_q <= cfg_wdata_i;
    end
  end

  // next state and records for one byte
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    inval_d = inval_q;
    pb_d    = pb_q;
    pv_d    = pv_q;
    n       = 2'd0;
    recs    = '0;
    sep     = soh_q ? SepSoh : SepPipe;
    wide    = '0;
    lim     = '0;
    tagv    = tag_to_out(neg_q, mag_q);

    if (consume_i) begin
      if (byte_i == sep) begin
        // separator closes the field
        if (inval_d) begin
          recs[n] = pv_d ? rec_t'{KIND_VALUE, tagv, pb_d, 1'b1}
                         : rec_t'{KIND_EMPTY, tagv, 8'h00, 1'b1};
          n = n + 2'd1;
        end
        phase_d = PH_START;
        neg_d   = 1'b0;
        mag_d   = '0;
        inval_d = 1'b0;
        pb_d    = 8'h00;
        pv_d    = 1'b0;
      end else begin
        // tag accumulate candidate: mag * 10 + digit against the signed limit
        lim  = neg_q ? TagHalf : (TagHalf - TagBits'(1));
        wide = (TagWideW'(mag_q) << 3) + (TagWideW'(mag_q) << 1)
             + TagWideW'(byte_i[3:0]);
        unique case (phase_q)
          PH_START: begin
            if (is_space(byte_i)) begin
              phase_d = PH_START;
            end else if (byte_i == PlusCh || byte_i == MinusCh) begin
              neg_d   = (byte_i == MinusCh);
              phase_d = PH_SIGN;
            end else if (is_digit(byte_i)) begin
              if (wide > TagWideW'(lim)) begin
                phase_d = PH_REJECT;
              end else begin
                phase_d = PH_DIGITS;
                mag_d   = wide[TagBits-1:0];
              end
            end else begin
              phase_d = PH_REJECT;
            end
          end
          PH_SIGN: begin
            if (is_digit(byte_i)) begin
              if (wide > TagWideW'(lim)) begin
                phase_d = PH_REJECT;
              end else begin
                phase_d = PH_DIGITS;
                mag_d   = wide[TagBits-1:0];
              end
            end else begin
              phase_d = PH_REJECT;
            end
          end
          PH_DIGITS, PH_AFTER: begin
            if (byte_i == EqChar) begin
              phase_d = PH_VALUE;
              inval_d = 1'b1;
            end else if (phase_q == PH_DIGITS && is_digit(byte_i)) begin
              if (wide > TagWideW'(lim)) begin
                phase_d = PH_REJECT;
              end else begin
                mag_d = wide[TagBits-1:0];
              end
            end else begin
              phase_d = PH_AFTER;
            end
          end
          PH_VALUE: begin
            // release the held byte, hold the new one
            if (pv_q) begin
              recs[n] = rec_t'{KIND_VALUE, tagv, pb_q, 1'b0};
              n = n + 2'd1;
            end
            pb_d = byte_i;
            pv_d = 1'b1;
          end
          default: begin
            phase_d = PH_REJECT;
          end
        endcase
      end

      // end of message closes the field and adds the end marker
      if (eom_i) begin
        if (inval_d) begin
          recs[n] = pv_d ? rec_t'{KIND_VALUE, tagv, pb_d, 1'b1}
                         : rec_t'{KIND_EMPTY, tagv, 8'h00, 1'b1};
          n = n + 2'd1;
        end
        phase_d = PH_START;
        neg_d   = 1'b0;
        mag_d   = '0;
        inval_d = 1'b0;
        pb_d    = 8'h00;
        pv_d    = 1'b0;
        recs[n] = rec_t'{KIND_END, '0, 8'h00, 1'b0};
        n = n + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      inval_q <= 1'b0;
      pb_q    <= 8'h00;
      pv_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      inval_q <= inval_d;
      pb_q    <= pb_d;
      pv_q    <= pv_d;
    end
  end

  assign push_o.count = n;
  assign push_o.recs  = recs;

endmodule

FILE: hw/rtl/tvfp_out_queue.sv
// four-entry record queue, up to three writes and one read per cycle
module tvfp_out_queue import tvfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  input  logic              pop_i,
  output logic              room_o,
  output logic              valid_o,
  output rec_t              head_o,
  output logic [CountW-1:0] count_o
);

  rec_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // room for the largest burst one byte can cause
  assign room_o  = (count_q <= CountW'(QueueDepth - MaxRecs));
  assign count_d = count_q + CountW'(push_i.count) - CountW'(pop_i && valid_o);
  assign count_o = count_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop_i && valid_o);
      count_q  <= count_d;
    end
  end

  // entry writes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRecs; i++) begin
      if (2'(i) < push_i.count) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= push_i.recs[i];
      end
    end
  end

endmodule

FILE: hw/rtl/tag_value_field_parser_top.sv
// top level of the tag=value field parser
//
// Takes one message byte per transaction and emits value-byte, empty-field and
// end-of-message records. A byte is accepted every clock while the record queue
// holds at most one entry, so plain text and value bytes stream at one byte per
// cycle; a byte flagged as the end of message can cause up to three records,
// which drain one per cycle from the four-entry queue while m_axis_tready is
// high and hold off input until it has room again. Records pass the input
// register, then the queue. The user must write the separator register only
// while idle; the block does not enforce this. It applies from the next byte.
module tag_value_field_parser_top import tvfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // separator select: 1 = 0x01, 0 = '|'
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] field_tag, [39:32] value_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] record_kind
  output logic        m_axis_tlast    // last_of_field
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              hold_eom;
  logic              room;
  logic              consume;
  push_t             push;
  rec_t              head;
  logic [CountW-1:0] q_count;

  assign consume = hold_valid && room;

  tvfp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_eom_i     (s_axis_tlast),
    .consume_i    (consume),
    .hold_valid_o (hold_valid),
    .hold_byte_o  (hold_byte),
    .hold_eom_o   (hold_eom)
  );

  tvfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .consume_i   (consume),
    .byte_i      (hold_byte),
    .eom_i       (hold_eom),
    .push_o      (push)
  );

  tvfp_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .count_o (q_count)
  );

  // output packing
  assign m_axis_tdata = {head.vbyte, head.tag};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // checks

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CountW'(QueueDepth))
    else $error("record queue overflow");

  // records only come from a consumed byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !consume |-> push.count == 2'd0)
    else $error("records pushed without a byte");

  // end marker carries no tag, byte or last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_END) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("malformed end marker");

  // a byte flagged end of message always yields an end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && hold_eom) |-> push.count != 2'd0)
    else $error("end of message without records");

endmodule
